// ===== rtl/rgb565_weighted_blend_defines.svh =====
// Assertion macros used by the checker file of the RGB565 blend block.
`ifndef RGB565_WEIGHTED_BLEND_DEFINES_SVH
`define RGB565_WEIGHTED_BLEND_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define RGBWB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rgb565 blend check failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define RGBWB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rgb565 blend check failed");

`endif

// ===== rtl/rgbwb_pkg.sv =====
// Package with the constants and types shared by the RGB565 blend block.
package rgbwb_pkg;

    // RGB565 packing.
    localparam int COLOR_BITS  = 16;
    localparam int RED_SHIFT   = 11;
    localparam int GREEN_SHIFT = 5;
    localparam int RB_BITS     = 5;
    localparam int GREEN_BITS  = 6;

    // Every lane works on a channel widened to the green width, so all lanes
    // share one quotient width and one latency.
    localparam int CH_BITS = GREEN_BITS;

    // Default weight width.
    localparam int DEF_WEIGHT_BITS = 16;

    // Edges from the accepting edge to the edge that raises the result strobe:
    // input register, lane product stage, one divider stage per quotient bit
    // and the output register.
    localparam int PIPE_LAT = CH_BITS + 2;

    // Control that travels beside the lanes.
    typedef struct packed {
        logic vld;
        logic zero;
    } t_ctl;

endpackage

// ===== rtl/rgbwb_lane.sv =====
// One color channel lane: weighted sum with rounding and a pipelined divider.
module rgbwb_lane import rgbwb_pkg::*; #(
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic                   i_clk,
    input  logic [CH_BITS-1:0]     i_ch_a,
    input  logic [CH_BITS-1:0]     i_ch_b,
    input  logic [WEIGHT_BITS-1:0] i_w_a,
    input  logic [WEIGHT_BITS-1:0] i_w_b,
    input  logic [WEIGHT_BITS:0]   i_w_sum,
    output logic [CH_BITS-1:0]     o_quo
);

    localparam int SW = WEIGHT_BITS + 1;
    // The rounded numerator stays below 2^CH_BITS times the weight sum.
    localparam int NW = SW + CH_BITS;

    logic [NW-1:0]      n_num;
    logic [NW-1:0]      r_rem [0:CH_BITS-1];
    logic [SW-1:0]      r_div [0:CH_BITS-1];
    logic [CH_BITS-1:0] r_quo [1:CH_BITS];

    // Weighted sum plus half of the weight sum, so the quotient rounds to nearest.
    always_comb begin
        n_num = NW'(i_ch_a) * NW'(i_w_a) + NW'(i_ch_b) * NW'(i_w_b)
              + NW'(i_w_sum >> 1);
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= n_num;
        r_div[0] <= i_w_sum;
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar k = 0; k < CH_BITS; k++) begin : g_div
        localparam int SH = CH_BITS - 1 - k;

        logic [NW-1:0]      d_sh;
        logic               take;
        logic [CH_BITS-1:0] q_prev;

        assign d_sh = NW'(r_div[k]) << SH;
        assign take = (r_rem[k] >= d_sh);

        if (k == 0) begin : g_first
            assign q_prev = '0;
        end else begin : g_rest
            assign q_prev = r_quo[k];
        end

        always_ff @(posedge i_clk) begin
            r_quo[k+1] <= {q_prev[CH_BITS-2:0], take};
        end

        // The remainder and divisor move on except after the last bit.
        if (k < CH_BITS - 1) begin : g_pass
            always_ff @(posedge i_clk) begin
                r_rem[k+1] <= take ? (r_rem[k] - d_sh) : r_rem[k];
                r_div[k+1] <= r_div[k];
            end
        end
    end

    assign o_quo = r_quo[CH_BITS];

endmodule

// ===== rtl/rgbwb_merge.sv =====
// Merge stage: packs the lane quotients into RGB565 and raises the result strobe.
module rgbwb_merge import rgbwb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctl                  i_ctl,
    input  logic [CH_BITS-1:0]    i_red,
    input  logic [CH_BITS-1:0]    i_green,
    input  logic [CH_BITS-1:0]    i_blue,
    output logic                  o_done,
    output logic [COLOR_BITS-1:0] o_blended_color,
    output logic                  o_zero_weight
);

    logic                  r_done;
    logic [COLOR_BITS-1:0] r_color;
    logic                  r_zero;
    logic [COLOR_BITS-1:0] n_color;

    // Both weights zero gives black; otherwise pack the three channels.
    always_comb begin
        if (i_ctl.zero) begin
            n_color = '0;
        end else begin
            n_color = {i_red[RB_BITS-1:0], i_green[GREEN_BITS-1:0], i_blue[RB_BITS-1:0]};
        end
    end

    // The strobe is control state; the result payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_color <= n_color;
        r_zero  <= i_ctl.zero;
    end

    assign o_done          = r_done;
    assign o_blended_color = r_color;
    assign o_zero_weight   = r_zero;

endmodule

// ===== rtl/rgb565_weighted_blend.sv =====
// Top level of the RGB565 weighted blend: input register, three lanes, merge.
//
//  channel   handshake            payload
//  -------   ------------------   -----------------------------------------------
//  input     start, busy          i_color_a, i_color_b, i_weight_a, i_weight_b
//  result    o_done (one cycle)   o_blended_color, o_zero_weight
//
// One item is taken every clock cycle; busy stays low.
// A result leaves through the input register, one product stage and a six-stage
// restoring divider in each lane (one stage per quotient bit), then the output
// register.
// Reset clears only the control bits of the pipeline and the result strobe; there is no clearing pass.
// The receiver cannot stall, so the pipeline never holds and never drops an item.
module rgb565_weighted_blend import rgbwb_pkg::*; #(
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COLOR_BITS-1:0] i_color_a,
    input  logic [COLOR_BITS-1:0] i_color_b,
    input  logic [COLOR_BITS-1:0] i_weight_a,
    input  logic [COLOR_BITS-1:0] i_weight_b,
    output logic                  o_done,
    output logic [COLOR_BITS-1:0] o_blended_color,
    output logic                  o_zero_weight
);

    localparam int SW = WEIGHT_BITS + 1;

    logic [31:0]            w_a_ext;
    logic [31:0]            w_b_ext;
    logic [WEIGHT_BITS-1:0] n_w_a;
    logic [WEIGHT_BITS-1:0] n_w_b;
    logic [SW-1:0]          n_w_sum;

    logic [COLOR_BITS-1:0]  r_color_a;
    logic [COLOR_BITS-1:0]  r_color_b;
    logic [WEIGHT_BITS-1:0] r_w_a;
    logic [WEIGHT_BITS-1:0] r_w_b;
    logic [SW-1:0]          r_w_sum;
    t_ctl                   r_ctl [0:CH_BITS+1];

    logic [CH_BITS-1:0]     red_a, red_b, green_a, green_b, blue_a, blue_b;
    logic [CH_BITS-1:0]     red_q, green_q, blue_q;

    // The pipeline always moves, so a new item is welcome every cycle.
    assign busy = 1'b0;

    // Keep the low WEIGHT_BITS bits of each weight; the sum is one bit wider.
    assign w_a_ext = {16'b0, i_weight_a};
    assign w_b_ext = {16'b0, i_weight_b};
    assign n_w_a   = w_a_ext[WEIGHT_BITS-1:0];
    assign n_w_b   = w_b_ext[WEIGHT_BITS-1:0];
    assign n_w_sum = {1'b0, n_w_a} + {1'b0, n_w_b};

    // Input register.
    always_ff @(posedge i_clk) begin
        r_color_a <= i_color_a;
        r_color_b <= i_color_b;
        r_w_a     <= n_w_a;
        r_w_b     <= n_w_b;
        r_w_sum   <= n_w_sum;
    end

    // Control line that tracks each item through the lanes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= CH_BITS + 1; i++) begin
                r_ctl[i] <= '0;
            end
        end else begin
            r_ctl[0].vld  <= start && !busy;
            r_ctl[0].zero <= (n_w_sum == '0);
            for (int i = 1; i <= CH_BITS + 1; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
    end

    // Split both colors into channels, widened to the lane width.
    assign red_a   = CH_BITS'(r_color_a[RED_SHIFT +: RB_BITS]);
    assign red_b   = CH_BITS'(r_color_b[RED_SHIFT +: RB_BITS]);
    assign green_a = CH_BITS'(r_color_a[GREEN_SHIFT +: GREEN_BITS]);
    assign green_b = CH_BITS'(r_color_b[GREEN_SHIFT +: GREEN_BITS]);
    assign blue_a  = CH_BITS'(r_color_a[RB_BITS-1:0]);
    assign blue_b  = CH_BITS'(r_color_b[RB_BITS-1:0]);

    // Three lanes side by side, one per channel.
    rgbwb_lane #(.WEIGHT_BITS(WEIGHT_BITS)) u_lane_red (
        .i_clk   (i_clk),
        .i_ch_a  (red_a),
        .i_ch_b  (red_b),
        .i_w_a   (r_w_a),
        .i_w_b   (r_w_b),
        .i_w_sum (r_w_sum),
        .o_quo   (red_q)
    );

    rgbwb_lane #(.WEIGHT_BITS(WEIGHT_BITS)) u_lane_green (
        .i_clk   (i_clk),
        .i_ch_a  (green_a),
        .i_ch_b  (green_b),
        .i_w_a   (r_w_a),
        .i_w_b   (r_w_b),
        .i_w_sum (r_w_sum),
        .o_quo   (green_q)
    );

    rgbwb_lane #(.WEIGHT_BITS(WEIGHT_BITS)) u_lane_blue (
        .i_clk   (i_clk),
        .i_ch_a  (blue_a),
        .i_ch_b  (blue_b),
        .i_w_a   (r_w_a),
        .i_w_b   (r_w_b),
        .i_w_sum (r_w_sum),
        .o_quo   (blue_q)
    );

    // Merge the lane results into one item.
    rgbwb_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (r_ctl[CH_BITS+1]),
        .i_red           (red_q),
        .i_green         (green_q),
        .i_blue          (blue_q),
        .o_done          (o_done),
        .o_blended_color (o_blended_color),
        .o_zero_weight   (o_zero_weight)
    );

endmodule

// ===== rtl/rgbwb_checker.sv =====
// Port-level checks for the RGB565 blend block and their bind to the top level.
`include "rgb565_weighted_blend_defines.svh"

module rgbwb_checker import rgbwb_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_done,
    input logic [COLOR_BITS-1:0] o_blended_color,
    input logic                  o_zero_weight
);

    // The strobe is raised by the output register at the end of the pipeline, so it is
    // first sampled high at the edge after the one that raises it.
    localparam int CHK_LAT = PIPE_LAT + 1;

    // Every result strobe belongs to an item taken a fixed latency earlier.
    `RGBWB_ASSERT_IMPL(a_done_has_item, o_done, $past(start && !busy, CHK_LAT))

    // Every accepted item comes out after the fixed latency.
    `RGBWB_ASSERT_IMPL(a_item_gives_done, start && !busy, ##CHK_LAT o_done)

    // A result flagged for zero weights carries black.
    `RGBWB_ASSERT_IMPL(a_zero_is_black, o_done && o_zero_weight, o_blended_color == '0)

    // The block never refuses an item.
    `RGBWB_ASSERT_NEXT(a_never_busy, 1'b1, !busy)

endmodule

bind rgb565_weighted_blend rgbwb_checker u_rgbwb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_blended_color (o_blended_color),
    .o_zero_weight   (o_zero_weight)
);
